>>> rtl/atp_pkg.sv
package atp_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;   // unsigned 12.4 sample
    localparam int COORD_W   = 8;    // pixel coordinate / config register
    localparam int PIDX_W    = 6;    // vertex number on the result beat
    localparam int CFG_IDX_W = 2;

    // Scaling works in 1/32 units
    localparam int SPAN_W    = SAMPLE_W + 1;           // lo32, span32
    localparam int YPROD_W   = SPAN_W + COORD_W;       // d * h
    localparam int YNUM_W    = YPROD_W + 1;            // d * h + span - 1

    // Minimum span: 0.5 is 8 in 12.4 units, 16 in 1/32 units
    localparam int SPAN_MIN_Q4 = 8;
    localparam int SPAN_MIN_Q5 = 16;

    localparam int SAMPLE_COUNT_DEF = 32;
    localparam int QUEUE_DEPTH      = 2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd3;

    localparam logic [COORD_W-1:0] LEFT_RST   = 8'd2;
    localparam logic [COORD_W-1:0] RIGHT_RST  = 8'd126;
    localparam logic [COORD_W-1:0] TOP_RST    = 8'd14;
    localparam logic [COORD_W-1:0] BOTTOM_RST = 8'd60;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample_value;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [PIDX_W-1:0]  point_index;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [COORD_W-1:0] plot_left;
        logic [COORD_W-1:0] plot_right;
        logic [COORD_W-1:0] plot_top;
        logic [COORD_W-1:0] plot_bottom;
    } cfg_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PLOT = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN_RD,
        BK_SCAN_CMP,
        BK_RANGE,
        BK_VTX_RD,
        BK_VTX_MUL,
        BK_VTX_GO,
        BK_VTX_DIV
    } bk_state_t;

endpackage

>>> rtl/atp_front.sv
module atp_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  atp_pkg::in_t item,
    output logic         q_valid,
    output atp_pkg::cmd_t q_cmd,
    input  logic         q_pop
);
    import atp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t              fifo_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    logic              accept;
    cmd_t              new_cmd;

    assign busy    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign accept  = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = fifo_mem[rd_ptr_reg];

    // classify the incoming beat
    always_comb
    begin
        new_cmd.op     = item.kind ? OP_PLOT : OP_PUSH;
        new_cmd.sample = item.sample_value;
    end

    always_comb
    begin
        wr_ptr_next = accept ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !q_pop)
        begin
            count_next = (PTR_W+1)'(count_reg + 1'b1);
        end
        else if (!accept && q_pop)
        begin
            count_next = (PTR_W+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fifo_mem[wr_ptr_reg] <= new_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");
`endif

endmodule

>>> rtl/atp_div.sv
module atp_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 17,
    parameter int Q_W   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);
    // Restoring divide, one quotient bit a cycle.
    // Caller guarantees num < den * 2**Q_W.
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [Q_W-1:0]   shq_reg;
    logic [Q_W-1:0]   shq_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, shq_reg[Q_W-1]};
    assign ge    = (trial >= {1'b0, den});

    always_comb
    begin
        rem_next = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        shq_next = {shq_reg[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(Q_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg - 1'b1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(num >> Q_W);
            shq_reg <= num[Q_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            shq_reg <= shq_next;
        end
    end

    assign done = done_reg;
    assign quot = shq_reg;

endmodule

>>> rtl/atp_back.sv
module atp_back #(
    parameter int SAMPLE_COUNT = atp_pkg::SAMPLE_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  atp_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  atp_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    output logic           strobe,
    output atp_pkg::out_t  point
);
    import atp_pkg::*;

    localparam int              IDX_W     = $clog2(SAMPLE_COUNT);
    localparam int              XNUM_W    = IDX_W + COORD_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SAMPLE_COUNT - 1);
    localparam logic [IDX_W-1:0] HEAD_INIT = IDX_W'(1 % SAMPLE_COUNT);

    // x divisor is the constant SAMPLE_COUNT-1: reciprocal multiply, exact
    // for every numerator that fits XNUM_W bits
    localparam int              XDEN      = SAMPLE_COUNT - 1;
    localparam int              XSHIFT    = XNUM_W + $clog2(XDEN);
    localparam int              XMUL_W    = XNUM_W + 2;
    localparam int              XPROD_W   = XNUM_W + XMUL_W;
    localparam logic [XMUL_W-1:0] XRECIP  = XMUL_W'((longint'(1) << XSHIFT) / XDEN + 1);

    bk_state_t           state_reg;
    bk_state_t           state_next;

    // ring storage; entries never written since the first push read as fill
    logic [SAMPLE_W-1:0] ring_mem [SAMPLE_COUNT];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic [SAMPLE_COUNT-1:0] vld_reg;
    logic [SAMPLE_W-1:0] fill_reg;
    logic                primed_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    k_reg;

    logic [SAMPLE_W-1:0] mn_reg;
    logic [SAMPLE_W-1:0] mx_reg;
    logic [SPAN_W-1:0]   lo_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [COORD_W-1:0]  w_reg;
    logic [COORD_W-1:0]  h_reg;
    logic [YNUM_W-1:0]   ynum_reg;
    logic [XNUM_W-1:0]   xnum_reg;
    logic [COORD_W-1:0]  x_quot_reg;
    out_t                point_reg;
    logic                strobe_reg;

    logic                ring_we;
    logic [IDX_W-1:0]    rd_addr;
    logic                div_start;
    logic                emit;
    logic                y_done;
    logic [COORD_W-1:0]  y_quot;
    logic [XPROD_W-1:0]  x_prod;

    logic [SAMPLE_W-1:0] rd_sample;
    logic [IDX_W:0]      pos_sum;
    logic [IDX_W-1:0]    vtx_addr;
    logic [SAMPLE_W-1:0] diff;
    logic [SPAN_W-1:0]   mid_sum;
    logic                narrow;
    logic [SPAN_W-1:0]   lo_calc;
    logic [SPAN_W-1:0]   span_calc;
    logic [SPAN_W-1:0]   s2;
    logic [SPAN_W-1:0]   d_val;
    logic [YPROD_W-1:0]  y_prod;

    assign rd_sample = rd_vld_reg ? rd_data_reg : fill_reg;

    // oldest-first address: (head + k) mod SAMPLE_COUNT
    assign pos_sum  = {1'b0, head_reg} + {1'b0, k_reg};
    assign vtx_addr = (pos_sum >= (IDX_W+1)'(SAMPLE_COUNT))
                    ? IDX_W'(pos_sum - (IDX_W+1)'(SAMPLE_COUNT))
                    : IDX_W'(pos_sum);

    // scale range in 1/32 units
    always_comb
    begin
        diff    = mx_reg - mn_reg;
        mid_sum = {1'b0, mn_reg} + {1'b0, mx_reg};
        narrow  = (diff < SAMPLE_W'(SPAN_MIN_Q4));
        if (narrow)
        begin
            span_calc = SPAN_W'(SPAN_MIN_Q5);
            lo_calc   = (mid_sum >= SPAN_W'(SPAN_MIN_Q4))
                      ? SPAN_W'(mid_sum - SPAN_W'(SPAN_MIN_Q4)) : '0;
        end
        else
        begin
            span_calc = {diff, 1'b0};
            lo_calc   = {mn_reg, 1'b0};
        end
    end

    assign s2     = {rd_sample, 1'b0};
    assign d_val  = (s2 > lo_reg) ? SPAN_W'(s2 - lo_reg) : '0;
    assign y_prod = YPROD_W'(d_val) * YPROD_W'(h_reg);

    // x: floor(k*w / (SAMPLE_COUNT-1))
    assign x_prod = XPROD_W'(xnum_reg) * XPROD_W'(XRECIP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_cmd.op == OP_PLOT)
                begin
                    state_next = BK_SCAN_RD;
                end
            end
            BK_SCAN_RD:  state_next = BK_SCAN_CMP;
            BK_SCAN_CMP: state_next = (k_reg == LAST_IDX) ? BK_RANGE : BK_SCAN_RD;
            BK_RANGE:    state_next = BK_VTX_RD;
            BK_VTX_RD:   state_next = BK_VTX_MUL;
            BK_VTX_MUL:  state_next = BK_VTX_GO;
            BK_VTX_GO:   state_next = BK_VTX_DIV;
            BK_VTX_DIV:
            begin
                if (y_done)
                begin
                    state_next = (k_reg == LAST_IDX) ? BK_IDLE : BK_VTX_RD;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop     = 1'b0;
        ring_we   = 1'b0;
        rd_addr   = vtx_addr;
        div_start = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop   = q_valid;
                ring_we = q_valid && (q_cmd.op == OP_PUSH) && primed_reg;
            end
            BK_SCAN_RD: rd_addr   = k_reg;
            BK_VTX_GO:  div_start = 1'b1;
            BK_VTX_DIV: emit      = y_done;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            strobe_reg <= 1'b0;
            primed_reg <= 1'b0;
            fill_reg   <= '0;
            head_reg   <= '0;
            vld_reg    <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
            if (q_pop && q_cmd.op == OP_PUSH)
            begin
                if (!primed_reg)
                begin
                    // first push stands for every entry
                    primed_reg <= 1'b1;
                    fill_reg   <= q_cmd.sample;
                    head_reg   <= HEAD_INIT;
                end
                else
                begin
                    vld_reg[head_reg] <= 1'b1;
                    head_reg <= (head_reg == LAST_IDX) ? '0 : IDX_W'(head_reg + 1'b1);
                end
            end
            case (state_reg)
                BK_IDLE:     k_reg <= '0;
                BK_SCAN_CMP: k_reg <= (k_reg == LAST_IDX) ? '0 : IDX_W'(k_reg + 1'b1);
                BK_VTX_DIV:
                begin
                    if (y_done)
                    begin
                        k_reg <= (k_reg == LAST_IDX) ? '0 : IDX_W'(k_reg + 1'b1);
                    end
                end
                default:     k_reg <= k_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[head_reg] <= q_cmd.sample;
        end
        rd_data_reg <= ring_mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];

        if (state_reg == BK_SCAN_CMP)
        begin
            if (k_reg == '0)
            begin
                mn_reg <= rd_sample;
                mx_reg <= rd_sample;
            end
            else
            begin
                if (rd_sample < mn_reg) mn_reg <= rd_sample;
                if (rd_sample > mx_reg) mx_reg <= rd_sample;
            end
        end

        if (state_reg == BK_RANGE)
        begin
            lo_reg   <= lo_calc;
            span_reg <= span_calc;
            w_reg    <= (cfg.plot_right > cfg.plot_left)
                      ? COORD_W'(cfg.plot_right - cfg.plot_left) : '0;
            h_reg    <= (cfg.plot_bottom > cfg.plot_top)
                      ? COORD_W'(cfg.plot_bottom - cfg.plot_top) : '0;
        end

        if (state_reg == BK_VTX_MUL)
        begin
            // ceil via num + span - 1
            ynum_reg <= YNUM_W'(y_prod) + YNUM_W'(span_reg) - YNUM_W'(1);
            xnum_reg <= XNUM_W'(k_reg) * XNUM_W'(w_reg);
        end

        // quotient never exceeds w, so 8 bits suffice
        if (state_reg == BK_VTX_GO)
        begin
            x_quot_reg <= COORD_W'(x_prod >> XSHIFT);
        end

        if (emit)
        begin
            point_reg.point_x     <= COORD_W'(cfg.plot_left + x_quot_reg);
            point_reg.point_y     <= COORD_W'(cfg.plot_bottom - y_quot);
            point_reg.point_index <= PIDX_W'(k_reg);
            point_reg.last        <= (k_reg == LAST_IDX);
        end
    end

    // y: quotient never exceeds h, so 8 bits suffice
    atp_div #(
        .NUM_W (YNUM_W),
        .DEN_W (SPAN_W),
        .Q_W   (COORD_W)
    ) u_ydiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ynum_reg),
        .den   (span_reg),
        .done  (y_done),
        .quot  (y_quot)
    );

    assign strobe = strobe_reg;
    assign point  = point_reg;

`ifndef ASSERT_OFF
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg) == BK_VTX_DIV)
        else $error("result beat without a finished divide");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && point_reg.last |-> point_reg.point_index == PIDX_W'(SAMPLE_COUNT - 1))
        else $error("last flag on wrong vertex");

    a_no_pop_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !point_reg.last |-> !q_pop)
        else $error("queue popped during a plot run");
`endif

endmodule

>>> rtl/autoscaled_trend_plot.sv
// Autoscaled trend plot: ring of the last SAMPLE_COUNT 12.4 samples, drawn as a
// min/max-normalized polyline.
//
// Input: a command beat (item) is taken at a clock edge where start is high and
// busy is low. kind 0 pushes sample_value into the ring, kind 1 asks for a plot.
// A two-entry command queue sits between the accept side and the engine, so
// busy only rises when both entries hold commands the engine has not reached.
// Output: each vertex is shown on point for one cycle with strobe high; the
// receiver cannot stall, so vertices stream out as they are computed.
// Config: cfg_we writes cfg_data into register cfg_index (left, right, top,
// bottom) at the clock edge; write only while the block is idle.
// Timing: a push is handled in the engine's idle state. A plot scans the ring
// (read and compare states per entry, one memory read port), sets the range,
// then per vertex does a read, a multiply and an 8-step shift/subtract divide.
// Reset: ring reads as all zero, head at 0, registers at 2/126/14/60; no
// clearing pass is needed.
module autoscaled_trend_plot #(
    parameter int SAMPLE_COUNT = atp_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  atp_pkg::in_t                   item,
    output logic                           strobe,
    output atp_pkg::out_t                  point,
    input  logic                           cfg_we,
    input  logic [atp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atp_pkg::COORD_W-1:0]    cfg_data
);
    import atp_pkg::*;

    cfg_t cfg_reg;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // plot window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plot_left   <= LEFT_RST;
            cfg_reg.plot_right  <= RIGHT_RST;
            cfg_reg.plot_top    <= TOP_RST;
            cfg_reg.plot_bottom <= BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT:   cfg_reg.plot_left   <= cfg_data;
                CFG_RIGHT:  cfg_reg.plot_right  <= cfg_data;
                CFG_TOP:    cfg_reg.plot_top    <= cfg_data;
                CFG_BOTTOM: cfg_reg.plot_bottom <= cfg_data;
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // accept side and command queue
    atp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // ring, scan and vertex engine
    atp_back #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .strobe  (strobe),
        .point   (point)
    );

endmodule
